@@ src/dq_pkg.sv @@
// shared types and constants of the double-ended queue
`default_nettype none
package dq_pkg;

	typedef enum logic [2:0] {
		MODE_PUSH_BACK  = 3'd0,
		MODE_PUSH_FRONT = 3'd1,
		MODE_POP_FRONT  = 3'd2,
		MODE_POP_BACK   = 3'd3,
		MODE_PEEK_FRONT = 3'd4,
		MODE_PEEK_BACK  = 3'd5,
		MODE_CLEAR      = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	localparam logic signed [31:0] NO_VALUE = -32'sd1;

	// per-cycle commands broadcast to every cell
	typedef struct packed {
		logic a_shr;
		logic a_shl;
		logic a_wr;
		logic b_shr;
		logic b_shl;
		logic b_wr;
	} cell_ctrl_t;

endpackage
`default_nettype wire

@@ src/dq_req_if.sv @@
// request channel carrying one queue operation
`default_nettype none
interface dq_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         mode;
	logic signed [31:0] push_value;

	modport source (output valid, output mode, output push_value, input ready);
	modport sink (input valid, input mode, input push_value, output ready);
endinterface
`default_nettype wire

@@ src/dq_rsp_if.sv @@
// response channel carrying one operation result
`default_nettype none
interface dq_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] read_value;
	logic [1:0]         status;
	logic [4:0]         fill_level;

	modport source (output valid, output read_value, output status, output fill_level,
		input ready);
	modport sink (input valid, input read_value, input status, input fill_level,
		output ready);
endinterface
`default_nettype wire

@@ src/double_ended_queue_unit.sv @@
// top level of the double-ended queue: cell row, count and result register
//
//  channel | dir | transaction payload
//  --------+-----+------------------------------------------
//  req     | in  | mode, push_value
//  rsp     | out | read_value, status, fill_level
//
// one operation per cycle while rsp is ready; each accepted request's response is registered and shows the next cycle
// the row holds the contents twice, front-aligned and back-aligned, so both
// ends sit in cell 0 and every shift moves data one cell per cycle
// reset clears the count and the response valid, cell contents need none
// req stalls only while a response waits in the output register
`default_nettype none
module double_ended_queue_unit #(
	parameter int DEPTH = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	dq_req_if.sink    req,
	dq_rsp_if.source  rsp
);
	import dq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic               accept;
	logic               full;
	logic               empty;
	mode_t              mode;
	cell_ctrl_t         ctrl;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_d;
	logic signed [31:0] rd_d;
	status_t            st_d;
	logic [CW+4:0]      count_ext;

	logic               rsp_valid_q;
	logic signed [31:0] rsp_value_q;
	status_t            rsp_status_q;
	logic [4:0]         rsp_fill_q;

	logic signed [31:0] a_w [DEPTH];
	logic signed [31:0] b_w [DEPTH];

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept = req.valid && req.ready;
	assign mode = mode_t'(req.mode);
	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		ctrl = '0;
		count_d = count_q;
		rd_d = NO_VALUE;
		st_d = ST_OK;
		case (mode)
			MODE_PUSH_BACK: begin
				if (full) begin
					st_d = ST_FULL;
				end else begin
					ctrl.a_wr = accept;
					ctrl.b_shr = accept;
					count_d = count_q + CW'(1);
				end
			end
			MODE_PUSH_FRONT: begin
				if (full) begin
					st_d = ST_FULL;
				end else begin
					ctrl.a_shr = accept;
					ctrl.b_wr = accept;
					count_d = count_q + CW'(1);
				end
			end
			MODE_POP_FRONT: begin
				if (empty) begin
					st_d = ST_EMPTY;
				end else begin
					rd_d = a_w[0];
					ctrl.a_shl = accept;
					count_d = count_q - CW'(1);
				end
			end
			MODE_POP_BACK: begin
				if (empty) begin
					st_d = ST_EMPTY;
				end else begin
					rd_d = b_w[0];
					ctrl.b_shl = accept;
					count_d = count_q - CW'(1);
				end
			end
			MODE_PEEK_FRONT: begin
				if (empty) begin
					st_d = ST_EMPTY;
				end else begin
					rd_d = a_w[0];
				end
			end
			MODE_PEEK_BACK: begin
				if (empty) begin
					st_d = ST_EMPTY;
				end else begin
					rd_d = b_w[0];
				end
			end
			MODE_CLEAR: begin
				count_d = '0;
			end
			default: begin
				count_d = count_q;
			end
		endcase
	end

	assign count_ext = {5'd0, count_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_value_q <= rd_d;
			rsp_status_q <= st_d;
			rsp_fill_q <= count_ext[4:0];
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.read_value = rsp_value_q;
	assign rsp.status = rsp_status_q;
	assign rsp.fill_level = rsp_fill_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [31:0] a_left;
		logic signed [31:0] a_right;
		logic signed [31:0] b_left;
		logic signed [31:0] b_right;

		if (i == 0) begin : g_head
			assign a_left = req.push_value;
			assign b_left = req.push_value;
		end else begin : g_body
			assign a_left = a_w[i-1];
			assign b_left = b_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign a_right = a_w[i];
			assign b_right = b_w[i];
		end else begin : g_inner
			assign a_right = a_w[i+1];
			assign b_right = b_w[i+1];
		end

		dq_cell #(
			.DEPTH (DEPTH),
			.INDEX (i)
		) u_cell (
			.clk     (clk),
			.ctrl    (ctrl),
			.count   (count_q),
			.value   (req.push_value),
			.a_left  (a_left),
			.a_right (a_right),
			.b_left  (b_left),
			.b_right (b_right),
			.a       (a_w[i]),
			.b       (b_w[i])
		);
	end
endmodule
`default_nettype wire

@@ src/dq_cell.sv @@
// one queue cell: a front-aligned and a back-aligned entry with neighbor shifts
`default_nettype none
module dq_cell #(
	parameter int DEPTH = 16,
	parameter int INDEX = 0
) (
	input  wire logic                           clk,
	input  wire dq_pkg::cell_ctrl_t             ctrl,
	input  wire logic [$clog2(DEPTH+1)-1:0]     count,
	input  wire logic signed [31:0]             value,
	input  wire logic signed [31:0]             a_left,
	input  wire logic signed [31:0]             a_right,
	input  wire logic signed [31:0]             b_left,
	input  wire logic signed [31:0]             b_right,
	output logic signed [31:0]                  a,
	output logic signed [31:0]                  b
);
	import dq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic hit;
	logic signed [31:0] a_q;
	logic signed [31:0] b_q;

	assign hit = (count == CW'(INDEX));

	always_ff @(posedge clk) begin
		if (ctrl.a_shr) begin
			a_q <= a_left;
		end else if (ctrl.a_shl) begin
			a_q <= a_right;
		end else if (ctrl.a_wr && hit) begin
			a_q <= value;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.b_shr) begin
			b_q <= b_left;
		end else if (ctrl.b_shl) begin
			b_q <= b_right;
		end else if (ctrl.b_wr && hit) begin
			b_q <= value;
		end
	end

	assign a = a_q;
	assign b = b_q;
endmodule
`default_nettype wire

@@ sim/tb_double_ended_queue_unit.sv @@
// testbench of double_ended_queue_unit: directed table and random traffic against a ring predictor
`timescale 1ns / 1ps

module tb_double_ended_queue_unit;
	import dq_pkg::*;

	localparam int QUEUE_DEPTH = 16;
	localparam int SLOT_BITS = $clog2(QUEUE_DEPTH);
	localparam logic [2:0] MODE_UNUSED = 3'd7;
	localparam int RANDOM_OPS = 1700;
	localparam int QUIET_OPS = 150;
	localparam int PRESSURE_AT = 600;
	localparam int PRESSURE_CYCLES = 150;
	localparam int DRAIN_CYCLES = 8;
	localparam int PRINT_CAP = 25;
	localparam int N_DIRECTED = 26;

	typedef struct packed {
		logic signed [31:0] read_value;
		status_t            status;
		logic [4:0]         fill_level;
	} op_result_t;

	typedef struct {
		logic [2:0]         op;
		logic signed [31:0] val;
		int                 reps;
		bit                 typed;
		op_result_t         want;
	} step_t;

	localparam op_result_t NOT_TYPED = '{NO_VALUE, ST_OK, 5'd0};

	step_t directed_steps [N_DIRECTED] = '{
		'{MODE_POP_FRONT,  32'sd0,            1, 1'b1, '{NO_VALUE, ST_EMPTY, 5'd0}},
		'{MODE_POP_BACK,   32'sd0,            1, 1'b1, '{NO_VALUE, ST_EMPTY, 5'd0}},
		'{MODE_PEEK_FRONT, 32'sd0,            1, 1'b1, '{NO_VALUE, ST_EMPTY, 5'd0}},
		'{MODE_PEEK_BACK,  32'sd0,            1, 1'b1, '{NO_VALUE, ST_EMPTY, 5'd0}},
		'{MODE_CLEAR,      32'sd0,            1, 1'b1, '{NO_VALUE, ST_OK, 5'd0}},
		'{MODE_UNUSED,     -32'sd1,           1, 1'b1, '{NO_VALUE, ST_OK, 5'd0}},
		'{MODE_PUSH_BACK,  32'sh7fffffff,     1, 1'b1, '{NO_VALUE, ST_OK, 5'd1}},
		'{MODE_PUSH_FRONT, 32'sh80000000,     1, 1'b1, '{NO_VALUE, ST_OK, 5'd2}},
		'{MODE_PEEK_FRONT, 32'sd0,            1, 1'b1, '{32'sh80000000, ST_OK, 5'd2}},
		'{MODE_PEEK_BACK,  32'sd0,            1, 1'b1, '{32'sh7fffffff, ST_OK, 5'd2}},
		'{MODE_UNUSED,     32'sh5a5a5a5a,     1, 1'b1, '{NO_VALUE, ST_OK, 5'd2}},
		'{MODE_POP_BACK,   32'sd0,            1, 1'b1, '{32'sh7fffffff, ST_OK, 5'd1}},
		'{MODE_POP_FRONT,  32'sd0,            1, 1'b1, '{32'sh80000000, ST_OK, 5'd0}},
		'{MODE_PUSH_FRONT, 32'sd0,            8, 1'b0, NOT_TYPED},
		'{MODE_PUSH_BACK,  -32'sd8,           8, 1'b0, NOT_TYPED},
		'{MODE_PUSH_BACK,  32'sh12345678,     1, 1'b1, '{NO_VALUE, ST_FULL, 5'd16}},
		'{MODE_PUSH_FRONT, -32'sd1,           1, 1'b1, '{NO_VALUE, ST_FULL, 5'd16}},
		'{MODE_PEEK_FRONT, 32'sd0,            1, 1'b0, NOT_TYPED},
		'{MODE_PEEK_BACK,  32'sd0,            1, 1'b0, NOT_TYPED},
		'{MODE_POP_BACK,   32'sd0,            3, 1'b0, NOT_TYPED},
		'{MODE_PUSH_BACK,  32'sh0f0f0f0f,     2, 1'b0, NOT_TYPED},
		'{MODE_POP_FRONT,  32'sd0,            4, 1'b0, NOT_TYPED},
		'{MODE_CLEAR,      32'sd0,            1, 1'b1, '{NO_VALUE, ST_OK, 5'd0}},
		'{MODE_PEEK_BACK,  32'sd0,            1, 1'b1, '{NO_VALUE, ST_EMPTY, 5'd0}},
		'{MODE_PUSH_BACK,  32'sd0,            1, 1'b1, '{NO_VALUE, ST_OK, 5'd1}},
		'{MODE_POP_FRONT,  32'sd0,            1, 1'b1, '{32'sd0, ST_OK, 5'd0}}
	};

	logic clk = 1'b0;
	logic arst_n;

	dq_req_if req_ch ();
	dq_rsp_if rsp_ch ();

	double_ended_queue_unit #(
		.DEPTH(QUEUE_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always #10 clk = ~clk;

	logic signed [31:0] ring_slots [QUEUE_DEPTH];
	int unsigned ring_front = 0;
	int unsigned ring_fill = 0;

	op_result_t awaited_results [$];
	int mismatch_count = 0;
	int ops_sent = 0;
	int results_seen = 0;
	int full_drops = 0;
	int empty_reads = 0;
	int clears_done = 0;
	int unsigned peak_fill = 0;
	bit gaps_on = 1'b0;
	bit quiet_end = 1'b0;
	bit pressure_done = 1'b0;

	function automatic op_result_t apply_queue_op(input logic [2:0] op,
		input logic signed [31:0] val);
		op_result_t r;
		int unsigned slot;
		r.read_value = NO_VALUE;
		r.status = ST_OK;
		if (op == MODE_PUSH_BACK || op == MODE_PUSH_FRONT) begin
			if (ring_fill >= QUEUE_DEPTH) begin
				r.status = ST_FULL;
			end else if (op == MODE_PUSH_BACK) begin
				ring_slots[SLOT_BITS'((ring_front + ring_fill) % QUEUE_DEPTH)] = val;
				ring_fill++;
			end else begin
				ring_front = (ring_front + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
				ring_slots[SLOT_BITS'(ring_front)] = val;
				ring_fill++;
			end
		end else if (op == MODE_POP_FRONT || op == MODE_POP_BACK ||
			op == MODE_PEEK_FRONT || op == MODE_PEEK_BACK) begin
			if (ring_fill == 0) begin
				r.status = ST_EMPTY;
			end else begin
				if (op == MODE_POP_FRONT || op == MODE_PEEK_FRONT)
					slot = ring_front;
				else
					slot = (ring_front + ring_fill - 1) % QUEUE_DEPTH;
				r.read_value = ring_slots[SLOT_BITS'(slot)];
				if (op == MODE_POP_FRONT) begin
					ring_front = (ring_front + 1) % QUEUE_DEPTH;
					ring_fill--;
				end else if (op == MODE_POP_BACK) begin
					ring_fill--;
				end
				if (ring_fill == 0)
					ring_front = 0;
			end
		end else if (op == MODE_CLEAR) begin
			ring_front = 0;
			ring_fill = 0;
		end
		r.fill_level = 5'(ring_fill);
		return r;
	endfunction

	function automatic logic [2:0] pick_op(input int unsigned push_share);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 2)
			return MODE_CLEAR;
		if (roll < 3)
			return MODE_UNUSED;
		if (roll < 3 + push_share)
			return $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
		case ($urandom_range(0, 3))
			0: return MODE_POP_FRONT;
			1: return MODE_POP_BACK;
			2: return MODE_PEEK_FRONT;
			default: return MODE_PEEK_BACK;
		endcase
	endfunction

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'sd0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("%0t ns result %0d %s: got %h, want %h", $time, results_seen, what,
				got, want);
	endtask

	task automatic offer_op(input logic [2:0] op, input logic signed [31:0] val,
		input bit use_typed, input op_result_t typed_want);
		op_result_t predicted;
		req_ch.valid <= 1'b1;
		req_ch.mode <= op;
		req_ch.push_value <= val;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predicted = apply_queue_op(op, val);
		awaited_results.insert(awaited_results.size(), use_typed ? typed_want : predicted);
		ops_sent++;
		if (predicted.status == ST_FULL)
			full_drops++;
		if (predicted.status == ST_EMPTY)
			empty_reads++;
		if (op == MODE_CLEAR)
			clears_done++;
		if (ring_fill > peak_fill)
			peak_fill = ring_fill;
		if (!quiet_end && gaps_on && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19))
				@(posedge clk);
		end
	endtask

	// response checker
	always @(posedge clk) begin
		op_result_t want;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			results_seen++;
			if (awaited_results.size() == 0) begin
				note_mismatch("transaction with nothing expected", rsp_ch.read_value, 32'hx);
			end else begin
				want = awaited_results[0];
				awaited_results.delete(0);
				if (rsp_ch.read_value !== want.read_value)
					note_mismatch("read_value", rsp_ch.read_value, want.read_value);
				if (rsp_ch.status !== want.status)
					note_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
				if (rsp_ch.fill_level !== want.fill_level)
					note_mismatch("fill_level", 32'(rsp_ch.fill_level), 32'(want.fill_level));
			end
		end
	end

	// response side backpressure
	initial begin
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!pressure_done && ops_sent >= PRESSURE_AT) begin
				rsp_ch.ready <= 1'b0;
				repeat (PRESSURE_CYCLES)
					@(posedge clk);
				pressure_done = 1'b1;
			end else begin
				rsp_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 40))
					@(posedge clk);
				if (!quiet_end && $urandom_range(0, 1)) begin
					rsp_ch.ready <= 1'b0;
					repeat ($urandom_range(1, 19))
						@(posedge clk);
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("timeout with %0d results outstanding", awaited_results.size());
		$display("double_ended_queue_unit: mismatch");
		$finish;
	end

	initial begin
		int unsigned push_share;
		int unsigned run_left;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.mode <= MODE_PUSH_BACK;
		req_ch.push_value <= 32'sd0;
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_steps[i]) begin
			for (int k = 0; k < directed_steps[i].reps; k++) begin
				gaps_on = 1'($urandom_range(0, 1));
				offer_op(directed_steps[i].op, directed_steps[i].val + k,
					directed_steps[i].typed, directed_steps[i].want);
			end
		end

		push_share = 48;
		run_left = 0;
		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (run_left == 0) begin
				run_left = $urandom_range(20, 60);
				case ($urandom_range(0, 2))
					0: push_share = 75;
					1: push_share = 20;
					default: push_share = 48;
				endcase
				gaps_on = 1'($urandom_range(0, 1));
			end
			run_left--;
			quiet_end = (n >= RANDOM_OPS - QUIET_OPS);
			offer_op(pick_op(push_share), pick_value(), 1'b0, NOT_TYPED);
		end

		req_ch.valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("ran %0d operations and checked %0d results, peak fill %0d of %0d",
			ops_sent, results_seen, peak_fill, QUEUE_DEPTH);
		$display("pushes dropped at full: %0d, reads of an empty queue: %0d, clears: %0d",
			full_drops, empty_reads, clears_done);
		if (mismatch_count == 0) begin
			$display("double_ended_queue_unit: match");
		end else begin
			$display("double_ended_queue_unit: mismatch");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/dq_pkg.sv
src/dq_req_if.sv
src/dq_rsp_if.sv
src/dq_cell.sv
src/double_ended_queue_unit.sv
sim/tb_double_ended_queue_unit.sv
